[src/bbah_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bbah_pkg
// Shared types and constants for the byte budget admission block.
// ----------------------------------------------------------------------------
package bbah_pkg;

   localparam int BYTE_W     = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic OP_RESERVE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_HARD_LIMIT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY   = CSR_IDX_W'(1);

   localparam logic [BYTE_W-1:0] HARD_LIMIT_RST = 32'd67108864;
   localparam logic [BYTE_W-1:0] RECOVERY_RST   = 32'd33554432;

   typedef struct packed {
      logic              operation;
      logic [BYTE_W-1:0] byte_count;
   } req_type;

   typedef struct packed {
      logic              granted;
      logic [BYTE_W-1:0] pending_total;
      logic [BYTE_W-1:0] peak_total;
      logic [BYTE_W-1:0] reject_count;
      logic              overload_flag;
      logic              underflow_error;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0] hard_limit;
      logic [BYTE_W-1:0] recovery_threshold;
   } cfg_type;

endpackage
`default_nettype wire

[src/bbah_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bbah_csr
// Configuration registers: hard limit and recovery threshold.
// ----------------------------------------------------------------------------
module bbah_csr
   import bbah_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HARD_LIMIT: cfg_in.hard_limit         = csr_data;
            CSR_RECOVERY:   cfg_in.recovery_threshold = csr_data;
            default:        cfg_in                    = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hard_limit         <= HARD_LIMIT_RST;
         cfg_ff.recovery_threshold <= RECOVERY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[src/bbah_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bbah_core
// Budget state and the admission decision for one request per cycle while fire is high.
// ----------------------------------------------------------------------------
module bbah_core
   import bbah_pkg::*;
#(
   parameter int CNT_W = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic fire,
   input  req_type   item,
   input  cfg_type   cfg,
   output rsp_type   result
);

   localparam logic [CNT_W-1:0] CNT_CAP = {CNT_W{1'b1}};

   logic [BYTE_W-1:0] pending_ff, pending_in;
   logic [BYTE_W-1:0] peak_ff, peak_in;
   logic [CNT_W-1:0]  rejects_ff, rejects_in;
   logic              latch_ff, latch_in;

   logic [BYTE_W-1:0] sum;
   logic [BYTE_W-1:0] diff;
   logic [BYTE_W-1:0] headroom;
   logic              above_thr;
   logic              over_limit;
   logic              is_zero;
   logic              under;
   logic              granted;
   logic              reject;

   always_comb begin
      sum        = pending_ff + item.byte_count;
      diff       = pending_ff - item.byte_count;
      headroom   = cfg.hard_limit - pending_ff;
      above_thr  = pending_ff > cfg.recovery_threshold;
      over_limit = (pending_ff > cfg.hard_limit) || (item.byte_count > headroom);
      is_zero    = item.byte_count == '0;

      pending_in = pending_ff;
      peak_in    = peak_ff;
      latch_in   = latch_ff;
      granted    = 1'b1;
      under      = 1'b0;
      reject     = 1'b0;

      if (item.operation == OP_RESERVE) begin
         if (!is_zero) begin
            if (latch_ff && above_thr) begin
               reject  = 1'b1;
               granted = 1'b0;
            end else if (over_limit) begin
               reject   = 1'b1;
               granted  = 1'b0;
               latch_in = above_thr;
            end else begin
               latch_in   = 1'b0;
               pending_in = sum;
               if (sum > peak_ff) begin
                  peak_in = sum;
               end
            end
         end
      end else begin
         if (!is_zero) begin
            under      = item.byte_count > pending_ff;
            pending_in = under ? '0 : diff;
            if (pending_in <= cfg.recovery_threshold) begin
               latch_in = 1'b0;
            end
         end
      end

      rejects_in = rejects_ff;
      if (reject && (rejects_ff != CNT_CAP)) begin
         rejects_in = rejects_ff + CNT_W'(1);
      end

      result.granted         = granted;
      result.pending_total   = pending_in;
      result.peak_total      = peak_in;
      result.reject_count    = BYTE_W'(rejects_in);
      result.overload_flag   = latch_in;
      result.underflow_error = under;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         peak_ff    <= '0;
         rejects_ff <= '0;
         latch_ff   <= 1'b0;
      end else if (fire) begin
         pending_ff <= pending_in;
         peak_ff    <= peak_in;
         rejects_ff <= rejects_in;
         latch_ff   <= latch_in;
      end
   end

endmodule
`default_nettype wire

[src/byte_budget_admission_hysteresis.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// byte_budget_admission_hysteresis
// Admission control of reserve and release requests against a byte budget.
// ----------------------------------------------------------------------------
// Each request word is registered on entry, decided combinationally against
// the pending, peak, rejection and overload state, and its result word is
// registered on exit. Throughput is one request per cycle while rsp_ready
// is held high; each request passes through the input and result registers
// before rsp valid. The rejection counter saturates at 2^COUNT_WIDTH - 1,
// capped at the 32-bit field maximum. CSR writes are always accepted and
// should be made only while no request is in flight.
// ----------------------------------------------------------------------------
module byte_budget_admission_hysteresis
   import bbah_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W = (COUNT_WIDTH < BYTE_W) ? COUNT_WIDTH : BYTE_W;

   cfg_type cfg;
   rsp_type result;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    advance;

   bbah_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bbah_core #(
      .CNT_W (CNT_W)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

endmodule
`default_nettype wire

[sim/tb_byte_budget_admission_hysteresis.sv]
// ----------------------------------------------------------------------------
// tb_byte_budget_admission_hysteresis
// Self-checking bench for the byte budget admission block.
// ----------------------------------------------------------------------------
// Runs directed reserve and release sequences that cover the limit, the
// overload latch and its recovery, underflow, and the register corners. It
// then sends random traffic under changing register settings, with sender
// gaps and receiver stalls. A bench-side model of the budget predicts every
// result word, and each received word is checked field by field.
// ----------------------------------------------------------------------------
module tb_byte_budget_admission_hysteresis;
   import bbah_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 115;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_HARD_LIMIT;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // budget model
   logic [BYTE_W-1:0] budget_limit   = HARD_LIMIT_RST;
   logic [BYTE_W-1:0] recover_level  = RECOVERY_RST;
   logic [BYTE_W-1:0] pending_model  = '0;
   logic [BYTE_W-1:0] peak_model     = '0;
   logic [BYTE_W-1:0] reject_model   = '0;
   logic              latch_model    = 1'b0;

   rsp_type expected_outcomes[$];
   rsp_type head_rsp;

   int error_count   = 0;
   int cycle_count   = 0;
   int send_gap_pct  = 0;
   int stall_pct     = 0;
   int words_sent    = 0;
   int grants_seen   = 0;
   int rejects_seen  = 0;
   int underflows    = 0;
   int latch_entries = 0;
   int csr_writes    = 0;

   byte_budget_admission_hysteresis uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic rsp_type predict_admission(req_type r);
      rsp_type res;
      logic    was_latched;
      res = '0;
      res.granted = 1'b1;
      was_latched = latch_model;
      if (r.operation == OP_RESERVE) begin
         if (r.byte_count != 0) begin
            if (latch_model && pending_model > recover_level) begin
               res.granted = 1'b0;
            end else begin
               latch_model = 1'b0;
               if (pending_model > budget_limit ||
                   r.byte_count > budget_limit - pending_model) begin
                  if (pending_model > recover_level) latch_model = 1'b1;
                  res.granted = 1'b0;
               end else begin
                  pending_model = pending_model + r.byte_count;
                  if (pending_model > peak_model) peak_model = pending_model;
               end
            end
            if (!res.granted && reject_model != '1) reject_model = reject_model + 1;
         end
      end else if (r.byte_count != 0) begin
         if (r.byte_count > pending_model) begin
            res.underflow_error = 1'b1;
            pending_model = '0;
         end else begin
            pending_model = pending_model - r.byte_count;
         end
         if (pending_model <= recover_level) latch_model = 1'b0;
      end
      res.pending_total = pending_model;
      res.peak_total    = peak_model;
      res.reject_count  = reject_model;
      res.overload_flag = latch_model;
      if (res.granted) grants_seen++; else rejects_seen++;
      if (res.underflow_error) underflows++;
      if (latch_model && !was_latched) latch_entries++;
      return res;
   endfunction

   function void check_field(string name, logic [BYTE_W-1:0] exp_val,
                             logic [BYTE_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outcomes.size() == 0) begin
            $error("result word with no outstanding request");
            error_count++;
         end else begin
            head_rsp = expected_outcomes.pop_front();
            check_field("granted", BYTE_W'(head_rsp.granted),
                        BYTE_W'(rsp_data.granted));
            check_field("pending_total", head_rsp.pending_total, rsp_data.pending_total);
            check_field("peak_total", head_rsp.peak_total, rsp_data.peak_total);
            check_field("reject_count", head_rsp.reject_count, rsp_data.reject_count);
            check_field("overload_flag", BYTE_W'(head_rsp.overload_flag),
                        BYTE_W'(rsp_data.overload_flag));
            check_field("underflow_error", BYTE_W'(head_rsp.underflow_error),
                        BYTE_W'(rsp_data.underflow_error));
         end
      end
   end

   // called at a clock edge; leaves req_valid high after the accept
   task automatic send_request(logic op, logic [BYTE_W-1:0] count);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_data  <= '{operation: op, byte_count: count};
      do @(posedge clock); while (!(req_valid && req_ready));
      expected_outcomes.push_back(predict_admission(req_data));
      words_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_outcomes.size() != 0);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      drain_results();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (idx == CSR_HARD_LIMIT) budget_limit = value;
      else if (idx == CSR_RECOVERY) recover_level = value;
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_default_budget();
      send_request(OP_RESERVE, 0);
      send_request(OP_RELEASE, 0);
      send_request(OP_RELEASE, 5);
      send_request(OP_RESERVE, 1000);
      send_request(OP_RESERVE, HARD_LIMIT_RST - 1000);
      send_request(OP_RESERVE, 1);
      send_request(OP_RESERVE, 0);
      send_request(OP_RESERVE, 5);
      send_request(OP_RELEASE, HARD_LIMIT_RST - RECOVERY_RST - 1);
      send_request(OP_RELEASE, 1);
      send_request(OP_RESERVE, 32'hFFFF_FFFF);
      send_request(OP_RELEASE, 32'hFFFF_FFFF);
      drain_results();
   endtask

   task automatic test_register_corners();
      write_register(CSR_HARD_LIMIT, 100);
      write_register(CSR_RECOVERY, 50);
      send_request(OP_RESERVE, 100);
      send_request(OP_RESERVE, 1);
      // threshold above limit: latch clears on reserve, limit check fails
      write_register(CSR_RECOVERY, 200);
      send_request(OP_RESERVE, 1);
      // limit dropped below pending
      write_register(CSR_HARD_LIMIT, 50);
      send_request(OP_RESERVE, 1);
      write_register(CSR_RECOVERY, 10);
      send_request(OP_RESERVE, 1);
      send_request(OP_RESERVE, 1);
      write_register(CSR_HARD_LIMIT, 32'hFFFF_FFFF);
      write_register(CSR_RECOVERY, 32'hFFFF_FFFE);
      send_request(OP_RELEASE, 32'hFFFF_FFFF);
      send_request(OP_RESERVE, 32'hFFFF_FFFF);
      send_request(OP_RESERVE, 1);
      send_request(OP_RELEASE, 1);
      send_request(OP_RELEASE, 32'hFFFF_FFFE);
      write_register(CSR_HARD_LIMIT, 1);
      write_register(CSR_RECOVERY, 0);
      send_request(OP_RESERVE, 1);
      send_request(OP_RESERVE, 1);
      send_request(OP_RELEASE, 1);
      drain_results();
   endtask

   task automatic test_random_traffic(int gap_pct, int stall);
      logic [BYTE_W-1:0] lim;
      logic [BYTE_W-1:0] thr;
      logic [BYTE_W-1:0] count;
      logic              op;
      case ($urandom_range(3))
         0: lim = $urandom_range(4000, 1);
         1: lim = $urandom_range(32'h0010_0000, 1);
         2: lim = ($urandom == 0) ? 1 : $urandom;
         default: lim = HARD_LIMIT_RST;
      endcase
      if (lim == 0) lim = 1;
      if ($urandom_range(7) == 0) thr = $urandom_range(32'hFFFF_FFFE, lim);
      else thr = $urandom_range(lim - 1, 0);
      write_register(CSR_HARD_LIMIT, lim);
      write_register(CSR_RECOVERY, thr);
      send_gap_pct = gap_pct;
      stall_pct    = stall;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         op = 1'($urandom_range(1));
         case ($urandom_range(9))
            0:       count = 0;
            1, 2:    count = $urandom;
            3, 4:    count = $urandom_range(budget_limit / 4 + 1, 1);
            5:       count = budget_limit - pending_model + $urandom_range(1);
            6:       count = pending_model + $urandom_range(1);
            7:       count = pending_model - recover_level + $urandom_range(1);
            default: count = $urandom_range(budget_limit, 0);
         endcase
         send_request(op, count);
         if (i == PHASE_ITEMS / 2) drain_results();
      end
      drain_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_budget();
      test_register_corners();
      test_random_traffic(10, 83);
      test_random_traffic(83, 10);
      test_random_traffic(0, 0);
      test_random_traffic(10, 83);
      test_random_traffic(0, 0);
      drain_results();
      repeat (10) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         $error("%0d results never arrived", expected_outcomes.size());
         error_count++;
      end
      $display("covered %0d request words, %0d register writes", words_sent, csr_writes);
      $display("grants %0d, rejects %0d, underflows %0d, overload entries %0d",
               grants_seen, rejects_seen, underflows, latch_entries);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[sim.f]
src/bbah_pkg.sv
src/bbah_csr.sv
src/bbah_core.sv
src/byte_budget_admission_hysteresis.sv
sim/tb_byte_budget_admission_hysteresis.sv
